// ===== hdl/pps_pkg.sv =====
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_RAN    = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;
  localparam logic [19:0] WORK_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  proc_id;
    logic [6:0]  priority_req;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  run_id;
    logic [15:0] seg_start;
    logic [15:0] seg_end;
    logic        finished;
  } out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [6:0]  prio;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] orig_burst;
  } entry_t;

  // True when entry a, loaded after entry b, is served before it.
  function automatic logic better(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else if (a.arrival != b.arrival) begin
      res = (a.arrival < b.arrival);
    end else begin
      res = (a.orig_burst < b.orig_burst);
    end
    return res;
  endfunction

endpackage

// ===== hdl/preemptive_priority_scheduler_top.sv =====
// Preemptive priority scheduler.
// Input transactions carry a kind: load a process entry, advance the schedule
// by one segment, or clear the table and the time. Every input transaction
// yields exactly one output transaction, in order.
// Loads, clears, unused kinds and advances with no work left answer in the cycle
// after acceptance. An advance that has work scans the process table through
// the single read port of the table memory, one entry per cycle, and answers
// from the finish state once the scan ends; that scan sets the throughput.
// One transaction is in flight at a time. in_stall is high while an advance
// is in progress, and while a result waits in the output register under out_stall.
// A result is held stable in the output register until out_stall is low.
// Reset empties the table, sets the time and the outstanding work to zero and
// drops any pending result; no clearing pass over the memory is needed.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      time_r, time_nxt;
  logic [19:0]      work_r, work_nxt;
  logic [CNT_W-1:0] iss_idx_r, iss_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             found_r, found_nxt;
  logic             have_r, have_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_ent_r, best_ent_nxt;
  logic [15:0]      next_arr_r, next_arr_nxt;

  logic             in_acc;
  logic [20:0]      load_sum;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             re;
  entry_t           rdata;
  entry_t           upd_ent;
  logic             alive;

  pps_table #(.MAX_PROCS(MAX_PROCS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (iss_idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_sum  = {1'b0, work_r} + 21'(in_data.burst_length);
  assign alive     = (rdata.remaining != 16'd0);

  always_comb begin
    upd_ent           = best_ent_r;
    upd_ent.remaining = best_ent_r.remaining - 16'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    work_nxt      = work_r;
    iss_idx_nxt   = iss_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_ent_nxt  = best_ent_r;
    next_arr_nxt  = next_arr_r;
    we            = 1'b0;
    waddr         = best_idx_r;
    wdata         = upd_ent;
    re            = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt        = '0;
          out_data_nxt.status = ST_LOADED;
          case (in_data.kind)
            KIND_LOAD: begin
              out_valid_nxt = 1'b1;
              if (count_r >= CNT_W'(MAX_PROCS) || load_sum > {1'b0, WORK_MAX}) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                we               = 1'b1;
                waddr            = count_r[IDX_W-1:0];
                wdata.id         = in_data.proc_id;
                wdata.prio       = in_data.priority_req;
                wdata.arrival    = in_data.arrival_time;
                wdata.remaining  = in_data.burst_length;
                wdata.orig_burst = in_data.burst_length;
                count_nxt        = count_r + CNT_W'(1);
                work_nxt         = load_sum[19:0];
              end
            end
            KIND_ADVANCE: begin
              if (work_r == 20'd0 || count_r == '0) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.status    = ST_DONE;
                out_data_nxt.seg_start = time_r;
                out_data_nxt.seg_end   = time_r;
              end else begin
                state_nxt   = S_SCAN;
                iss_idx_nxt = '0;
                cmp_vld_nxt = 1'b0;
                found_nxt   = 1'b0;
                have_nxt    = 1'b0;
              end
            end
            KIND_CLEAR: begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
              time_nxt      = 16'd0;
              work_nxt      = 20'd0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_idx_r < count_r) begin
          re          = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_idx_r[IDX_W-1:0];
          iss_idx_nxt = iss_idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r && alive) begin
          if (rdata.arrival <= time_r) begin
            if (!found_r || better(rdata, best_ent_r)) begin
              found_nxt    = 1'b1;
              best_idx_nxt = cmp_idx_r;
              best_ent_nxt = rdata;
            end
          end else if (!have_r || rdata.arrival < next_arr_r) begin
            have_nxt     = 1'b1;
            next_arr_nxt = rdata.arrival;
          end
        end
        if (iss_idx_r == count_r && !cmp_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        out_data_nxt           = '0;
        out_data_nxt.seg_start = time_r;
        if (found_r) begin
          we                    = 1'b1;
          work_nxt              = work_r - 20'd1;
          time_nxt              = (time_r == TIME_MAX) ? time_r : time_r + 16'd1;
          out_data_nxt.status   = ST_RAN;
          out_data_nxt.run_id   = best_ent_r.id;
          out_data_nxt.seg_end  = time_nxt;
          out_data_nxt.finished = (best_ent_r.remaining == 16'd1);
        end else if (have_r) begin
          time_nxt             = next_arr_r;
          out_data_nxt.status  = ST_IDLE;
          out_data_nxt.seg_end = next_arr_r;
        end else begin
          out_data_nxt.status  = ST_DONE;
          out_data_nxt.seg_end = time_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      time_r      <= 16'd0;
      work_r      <= 20'd0;
      iss_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      work_r      <= work_nxt;
      iss_idx_r   <= iss_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      have_r      <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
    next_arr_r <= next_arr_nxt;
  end

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while an advance is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("entry count exceeds table depth");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == KIND_CLEAR) |=>
      (work_r == 20'd0 && time_r == 16'd0 && count_r == '0))
    else $error("clear transaction did not empty the table");

  a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && found_r) |-> (best_ent_r.remaining != 16'd0 && work_r != 20'd0))
    else $error("selected process has no work left");

endmodule

// ===== hdl/pps_table.sv =====
module pps_table
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  localparam int IDX_W = $clog2(MAX_PROCS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_PROCS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/preemptive_priority_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module preemptive_priority_scheduler_top_tb;
  import pps_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = MAX_PROCS_DEF;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic drain;
    in_t  data;
  } cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  cmd_t cmd_queue[$];
  out_t expected_segments[$];

  entry_t      proc_table[TABLE_DEPTH];
  int          table_count = 0;
  logic [15:0] sched_time = '0;
  int          work_total = 0;

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit drv_valid = 1'b0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int in_gap = 0;
  int out_wait = 0;
  int mismatches = 0;

  preemptive_priority_scheduler_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic out_t schedule_step(in_t item);
    out_t        res;
    int          pick;
    bit          wins;
    bit          have_next;
    logic [15:0] next_arrival;
    res = '0;
    res.status = ST_LOADED;
    pick = -1;
    have_next = 1'b0;
    next_arrival = '0;
    case (item.kind)
      KIND_LOAD: begin
        if (table_count >= TABLE_DEPTH ||
            work_total + int'(item.burst_length) > int'(WORK_MAX)) begin
          res.status = ST_FULL;
        end else begin
          proc_table[table_count].id = item.proc_id;
          proc_table[table_count].prio = item.priority_req;
          proc_table[table_count].arrival = item.arrival_time;
          proc_table[table_count].remaining = item.burst_length;
          proc_table[table_count].orig_burst = item.burst_length;
          table_count++;
          work_total += int'(item.burst_length);
        end
      end
      KIND_CLEAR: begin
        table_count = 0;
        sched_time = '0;
        work_total = 0;
      end
      KIND_ADVANCE: begin
        if (work_total == 0) begin
          res.status = ST_DONE;
          res.seg_start = sched_time;
          res.seg_end = sched_time;
        end else begin
          for (int i = 0; i < table_count; i++) begin
            if (proc_table[i].remaining != 0 && proc_table[i].arrival <= sched_time) begin
              if (pick < 0) begin
                wins = 1'b1;
              end else if (proc_table[i].prio != proc_table[pick].prio) begin
                wins = proc_table[i].prio < proc_table[pick].prio;
              end else if (proc_table[i].arrival != proc_table[pick].arrival) begin
                wins = proc_table[i].arrival < proc_table[pick].arrival;
              end else begin
                wins = proc_table[i].orig_burst < proc_table[pick].orig_burst;
              end
              if (wins) begin
                pick = i;
              end
            end
          end
          if (pick >= 0) begin
            res.status = ST_RAN;
            res.run_id = proc_table[pick].id;
            res.seg_start = sched_time;
            proc_table[pick].remaining = proc_table[pick].remaining - 16'd1;
            work_total--;
            if (sched_time != TIME_MAX) begin
              sched_time = sched_time + 16'd1;
            end
            res.seg_end = sched_time;
            res.finished = (proc_table[pick].remaining == 0);
          end else begin
            for (int i = 0; i < table_count; i++) begin
              if (proc_table[i].remaining != 0 && proc_table[i].arrival > sched_time) begin
                if (!have_next || proc_table[i].arrival < next_arrival) begin
                  next_arrival = proc_table[i].arrival;
                  have_next = 1'b1;
                end
              end
            end
            res.seg_start = sched_time;
            if (have_next) begin
              res.status = ST_IDLE;
              res.seg_end = next_arrival;
              sched_time = next_arrival;
            end else begin
              res.status = ST_DONE;
              res.seg_end = sched_time;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Both channels are sampled here, ahead of any update that the edge causes.
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        expected_segments.push_back(schedule_step(in_data));
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (expected_segments.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transaction: status %0d id %0h start %0d end %0d fin %0b",
                     out_data.status, out_data.run_id, out_data.seg_start,
                     out_data.seg_end, out_data.finished);
          end
        end else begin
          want = expected_segments.pop_front();
          if (out_data.status !== want.status || out_data.run_id !== want.run_id ||
              out_data.seg_start !== want.seg_start || out_data.seg_end !== want.seg_end ||
              out_data.finished !== want.finished) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: status %0d/%0d id %0h/%0h start %0d/%0d end %0d/%0d fin %0b/%0b",
                       want.status, out_data.status, want.run_id, out_data.run_id,
                       want.seg_start, out_data.seg_start, want.seg_end, out_data.seg_end,
                       want.finished, out_data.finished);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        in_took = 1'b0;
        void'(cmd_queue.pop_front());
        drv_valid = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          quiet_in = !quiet_in;
        end
        in_gap = quiet_in ? 0 : $urandom_range(0, 4);
      end
      if (!drv_valid && cmd_queue.size() != 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!cmd_queue[0].drain || expected_segments.size() == 0) begin
          drv_valid = 1'b1;
          in_data <= cmd_queue[0].data;
        end
      end
      in_valid <= drv_valid;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_took = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          quiet_out = !quiet_out;
        end
        out_wait = quiet_out ? 0 : $urandom_range(0, 4);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_cmd(logic [1:0] k, logic [7:0] id, logic [6:0] pr,
                          logic [15:0] arr, logic [15:0] burst, bit drain);
    cmd_t c;
    c.drain = drain;
    c.data.kind = k;
    c.data.proc_id = id;
    c.data.priority_req = pr;
    c.data.arrival_time = arr;
    c.data.burst_length = burst;
    cmd_queue.push_back(c);
  endtask

  task automatic push_random_load(bit drain);
    logic [6:0]  pr;
    logic [15:0] arr;
    logic [15:0] burst;
    pr = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
    arr = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    burst = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    push_cmd(KIND_LOAD, 8'($urandom), pr, arr, burst, drain);
  endtask

  task automatic push_random_advance();
    push_cmd(KIND_ADVANCE, 8'($urandom), 7'($urandom), 16'($urandom), 16'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int  made;
    int  n;
    bit  drain;
    logic [1:0] k;

    push_cmd(KIND_ADVANCE, 8'h00, 7'd0, 16'd0, 16'd0, 1'b0);
    push_cmd(KIND_UNUSED, 8'hFF, 7'd127, 16'hFFFF, 16'hFFFF, 1'b0);
    push_cmd(KIND_LOAD, 8'h01, 7'd5, 16'd0, 16'd2, 1'b0);
    push_cmd(KIND_LOAD, 8'h02, 7'd5, 16'd0, 16'd1, 1'b0);
    push_cmd(KIND_LOAD, 8'h03, 7'd5, 16'd0, 16'd1, 1'b0);
    push_cmd(KIND_LOAD, 8'h04, 7'd3, 16'd1, 16'd1, 1'b0);
    push_cmd(KIND_LOAD, 8'h05, 7'd5, 16'd1, 16'd1, 1'b0);
    push_cmd(KIND_LOAD, 8'hFF, 7'd127, 16'hFFFF, 16'd2, 1'b0);
    push_cmd(KIND_LOAD, 8'h00, 7'd0, 16'd0, 16'd0, 1'b0);
    for (int i = 0; i < 10; i++) begin
      push_cmd(KIND_ADVANCE, 8'h00, 7'd0, 16'd0, 16'd0, 1'b0);
    end
    push_cmd(KIND_CLEAR, 8'hFF, 7'd127, 16'hFFFF, 16'hFFFF, 1'b1);

    // Mostly well-formed schedules: an optional clear, a table load, then a run of advances.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      drain = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) != 0) begin
        if ($urandom_range(0, 4) != 0) begin
          push_cmd(KIND_CLEAR, 8'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                   drain);
          made++;
          drain = 1'b0;
        end
        n = $urandom_range(1, 18);
        for (int i = 0; i < n; i++) begin
          push_random_load(drain);
          drain = 1'b0;
        end
        made += n;
        n = $urandom_range(4, 40);
        for (int i = 0; i < n; i++) begin
          push_random_advance();
        end
        made += n;
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          k = 2'($urandom_range(0, 3));
          push_cmd(k, 8'($urandom), 7'($urandom), 16'($urandom), 16'($urandom), drain);
          drain = 1'b0;
          if (k != KIND_UNUSED) begin
            made++;
          end
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || expected_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
